// ===== hdl/arlc_pkg.sv =====
// ----------------------------------------------------------------------------
// arlc_pkg
// Shared types, constants and pattern tables for the response line classifier.
// ----------------------------------------------------------------------------
package arlc_pkg;

  // line store geometry
  localparam int LINE_BYTES = 64;
  localparam int CNT_W      = $clog2(LINE_BYTES);

  // pattern table geometry
  localparam int PAT_MAX  = 21;
  localparam int PAT_W    = 8 * PAT_MAX;
  localparam int NUM_PAT  = 16;
  localparam int EVT_OFF  = 5;
  localparam int MC_LEN   = 9;

  // pattern ids, line-level words first
  localparam int P_OK         = 0;
  localparam int P_PARAM_ERR  = 1;
  localparam int P_BUSY_ERR   = 2;
  localparam int P_NO_NET     = 3;
  localparam int P_AT_ERR     = 4;
  localparam int P_RX_ERR     = 5;
  localparam int P_EVT        = 6;
  localparam int P_JOINED     = 7;
  localparam int P_JOIN_FAIL  = 8;
  localparam int P_TX_DONE    = 9;
  localparam int P_CONF_OK    = 10;
  localparam int P_CONF_FAIL  = 11;
  localparam int P_RX         = 12;
  localparam int P_P2P_TX     = 13;
  localparam int P_P2P_RX     = 14;
  localparam int P_LINKCHECK  = 15;
  localparam int P_MCAST      = 16;

  // special bytes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // line kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_VALUE   = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_PARAM_ERR = 3'd1;
  localparam logic [2:0] STS_BUSY      = 3'd2;
  localparam logic [2:0] STS_NO_NET    = 3'd3;
  localparam logic [2:0] STS_ERROR     = 3'd4;

  // event codes
  localparam logic [3:0] EVK_JOINED    = 4'd0;
  localparam logic [3:0] EVK_JOIN_FAIL = 4'd1;
  localparam logic [3:0] EVK_TX_DONE   = 4'd2;
  localparam logic [3:0] EVK_CONF_OK   = 4'd3;
  localparam logic [3:0] EVK_CONF_FAIL = 4'd4;
  localparam logic [3:0] EVK_RX        = 4'd5;
  localparam logic [3:0] EVK_P2P_TX    = 4'd6;
  localparam logic [3:0] EVK_P2P_RX    = 4'd7;
  localparam logic [3:0] EVK_LINKCHECK = 4'd8;
  localparam logic [3:0] EVK_MAX       = 4'd8;

  // token counter: tokens after the port token are ignored
  localparam logic [2:0] TOK_RSSI = 3'd2;
  localparam logic [2:0] TOK_SNR  = 3'd3;
  localparam logic [2:0] TOK_MC   = 3'd4;
  localparam logic [2:0] TOK_PORT = 3'd5;
  localparam logic [2:0] TOK_SAT  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_CLOSE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_WS,
    PH_DIG,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic store;
    logic start;
    logic walk;
    logic close;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_lf;
    logic in_cr;
    logic line_empty;
    logic reads_done;
    logic out_free;
  } stat_t;

  function automatic logic [PAT_W-1:0] pat_str(int id);
    logic [PAT_W-1:0] s;
    unique case (id)
      P_OK:        s = "OK";
      P_PARAM_ERR: s = {"AT_PARAM", "_ERROR"};
      P_BUSY_ERR:  s = {"AT_BUSY", "_ERROR"};
      P_NO_NET:    s = {"AT_NO_NETWORK", "_JOINED"};
      P_AT_ERR:    s = {"AT_", "ERROR"};
      P_RX_ERR:    s = {"AT_RX", "_ERROR"};
      P_EVT:       s = "+EVT:";
      P_JOINED:    s = "JOINED";
      P_JOIN_FAIL: s = {"JOIN", "_FAILED"};
      P_TX_DONE:   s = "TX_DONE";
      P_CONF_OK:   s = {"SEND_CONFIRMED", "_OK"};
      P_CONF_FAIL: s = {"SEND_CONFIRMED", "_FAILED"};
      P_RX:        s = "RX_";
      P_P2P_TX:    s = "TXP2P DONE";
      P_P2P_RX:    s = "RXP2P";
      P_LINKCHECK: s = "LINKCHECK";
      P_MCAST:     s = "MULTICAST";
      default:     s = '0;
    endcase
    return s;
  endfunction

  function automatic int pat_len(int id);
    int n;
    unique case (id)
      P_OK:        n = 2;
      P_PARAM_ERR: n = 14;
      P_BUSY_ERR:  n = 13;
      P_NO_NET:    n = 20;
      P_AT_ERR:    n = 8;
      P_RX_ERR:    n = 11;
      P_EVT:       n = 5;
      P_JOINED:    n = 6;
      P_JOIN_FAIL: n = 11;
      P_TX_DONE:   n = 7;
      P_CONF_OK:   n = 17;
      P_CONF_FAIL: n = 21;
      P_RX:        n = 3;
      P_P2P_TX:    n = 10;
      P_P2P_RX:    n = 5;
      P_LINKCHECK: n = 9;
      P_MCAST:     n = MC_LEN;
      default:     n = 0;
    endcase
    return n;
  endfunction

  // event names start after the event prefix
  function automatic int pat_off(int id);
    return (id > P_EVT) ? EVT_OFF : 0;
  endfunction

  function automatic logic [7:0] pat_char(int id, int k);
    logic [PAT_W-1:0] s;
    int n;
    s = pat_str(id);
    n = pat_len(id);
    if (k < 0 || k >= n) return 8'h00;
    return s[8*(n-1-k) +: 8];
  endfunction

endpackage

// ===== hdl/arlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arlc_ctrl
// Sequencer: collects line bytes, then walks the store and finishes the line.
// ----------------------------------------------------------------------------
module arlc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  arlc_pkg::stat_t st,
  output arlc_pkg::cmd_t  cmd
);

  arlc_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= arlc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      arlc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !st.in_cr) begin
          if (!st.in_lf) begin
            cmd.store = 1'b1;
          end else if (!st.line_empty) begin
            cmd.start  = 1'b1;
            state_next = arlc_pkg::ST_WALK;
          end
        end
      end
      arlc_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
        if (st.reads_done) state_next = arlc_pkg::ST_DRAIN;
      end
      arlc_pkg::ST_DRAIN: begin
        state_next = arlc_pkg::ST_CLOSE;
      end
      arlc_pkg::ST_CLOSE: begin
        cmd.close  = 1'b1;
        state_next = arlc_pkg::ST_FINISH;
      end
      arlc_pkg::ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = arlc_pkg::ST_IDLE;
        end
      end
      default: state_next = arlc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/arlc_datapath.sv =====
// ----------------------------------------------------------------------------
// arlc_datapath
// Line store, byte-serial pattern matchers, rx field tokenizer, result register.
// ----------------------------------------------------------------------------
module arlc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  arlc_pkg::cmd_t     cmd,
  output arlc_pkg::stat_t    st,
  input  logic [7:0]         rx_byte,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         line_kind,
  output logic [2:0]         status_code,
  output logic [3:0]         event_kind,
  output logic signed [15:0] rx_rssi,
  output logic signed [15:0] rx_snr,
  output logic               rx_multicast,
  output logic [7:0]         rx_port,
  output logic [5:0]         value_length
);

  localparam int CW = arlc_pkg::CNT_W;

  logic [7:0]    mem [arlc_pkg::LINE_BYTES];
  logic [CW-1:0] line_count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] proc_pos;
  logic          proc_v;
  logic [7:0]    mem_q;
  logic          stopped;
  logic [CW-1:0] eff;
  logic [arlc_pkg::NUM_PAT-1:0] flags, flags_next;

  // tokenizer state
  logic             in_tok, in_tok_next;
  logic [2:0]       tok_cnt, tok_cnt_next;
  logic [CW-1:0]    tok_len, tok_len_next;
  arlc_pkg::phase_t phase, phase_next;
  logic [15:0]      acc, acc_next;
  logic             neg, neg_next;
  logic             mc_ok, mc_ok_next;
  logic             close_now;

  // candidate rx fields
  logic [15:0] cand_rssi, cand_snr;
  logic [7:0]  cand_port;
  logic        cand_mc;
  logic        cand_rssi_v, cand_snr_v, cand_mc_v, cand_port_v;

  // held values
  logic [15:0] held_rssi, held_snr;
  logic        held_mc;
  logic [7:0]  held_port;
  logic [5:0]  held_vlen;
  logic [15:0] held_rssi_next, held_snr_next;
  logic        held_mc_next;
  logic [7:0]  held_port_next;
  logic [5:0]  held_vlen_next;

  logic        act;
  logic [15:0] tok_val;
  logic [1:0]  kind_c;
  logic [2:0]  status_c;
  logic [3:0]  evk_c;

  // status to controller
  always_comb begin
    st.in_lf      = (rx_byte == arlc_pkg::CH_LF);
    st.in_cr      = (rx_byte == arlc_pkg::CH_CR);
    st.line_empty = (line_count == '0);
    st.reads_done = (rd_ptr == line_count);
    st.out_free   = !out_valid || !out_stall;
  end

  // line store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.store && line_count < CW'(arlc_pkg::LINE_BYTES - 1)) begin
      mem[line_count] <= rx_byte;
    end
    mem_q <= mem[rd_ptr];
  end

  // byte count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      rd_ptr     <= '0;
      proc_v     <= 1'b0;
    end else begin
      if (cmd.store && line_count < CW'(arlc_pkg::LINE_BYTES - 1)) begin
        line_count <= line_count + 1'b1;
      end else if (cmd.finish) begin
        line_count <= '0;
      end
      if (cmd.start) begin
        rd_ptr <= '0;
        proc_v <= 1'b0;
      end else if (cmd.walk && !st.reads_done) begin
        rd_ptr <= rd_ptr + 1'b1;
        proc_v <= 1'b1;
      end else begin
        proc_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_pos <= rd_ptr;
  end

  assign act = proc_v && !stopped && (mem_q != 8'h00);

  // pattern matchers: one byte per cycle against every line and event word
  always_comb begin
    int off, len, p;
    flags_next = flags;
    for (p = 0; p < arlc_pkg::NUM_PAT; p++) begin
      off = arlc_pkg::pat_off(p);
      len = arlc_pkg::pat_len(p);
      if (int'(proc_pos) >= off && int'(proc_pos) < off + len &&
          mem_q != arlc_pkg::pat_char(p, int'(proc_pos) - off)) begin
        flags_next[p] = 1'b0;
      end
    end
  end

  // rx tokenizer: colon-separated fields after the event prefix
  always_comb begin
    in_tok_next  = in_tok;
    tok_cnt_next = tok_cnt;
    tok_len_next = tok_len;
    phase_next   = phase;
    acc_next     = acc;
    neg_next     = neg;
    mc_ok_next   = mc_ok;
    close_now    = 1'b0;
    if (act && int'(proc_pos) >= arlc_pkg::EVT_OFF) begin
      if (mem_q == arlc_pkg::CH_COLON) begin
        close_now   = in_tok;
        in_tok_next = 1'b0;
      end else begin
        if (!in_tok) begin
          tok_cnt_next = (tok_cnt == arlc_pkg::TOK_SAT) ? tok_cnt : tok_cnt + 1'b1;
          tok_len_next = '0;
          phase_next   = arlc_pkg::PH_WS;
          acc_next     = '0;
          neg_next     = 1'b0;
          mc_ok_next   = 1'b1;
        end
        in_tok_next = 1'b1;
        // multicast word match
        mc_ok_next = mc_ok_next && (int'(tok_len_next) < arlc_pkg::MC_LEN) &&
                     (mem_q == arlc_pkg::pat_char(arlc_pkg::P_MCAST, int'(tok_len_next)));
        tok_len_next = tok_len_next + 1'b1;
        // number parse
        case (phase_next)
          arlc_pkg::PH_WS: begin
            if (mem_q == arlc_pkg::CH_SPACE ||
                (mem_q >= arlc_pkg::CH_TAB && mem_q <= arlc_pkg::CH_CR)) begin
              phase_next = arlc_pkg::PH_WS;
            end else if (mem_q == arlc_pkg::CH_PLUS || mem_q == arlc_pkg::CH_MINUS) begin
              neg_next   = (mem_q == arlc_pkg::CH_MINUS);
              phase_next = arlc_pkg::PH_DIG;
            end else if (mem_q >= arlc_pkg::CH_ZERO && mem_q <= arlc_pkg::CH_NINE) begin
              acc_next   = {12'd0, mem_q[3:0]};
              phase_next = arlc_pkg::PH_DIG;
            end else begin
              phase_next = arlc_pkg::PH_DONE;
            end
          end
          arlc_pkg::PH_DIG: begin
            if (mem_q >= arlc_pkg::CH_ZERO && mem_q <= arlc_pkg::CH_NINE) begin
              acc_next = {acc_next[12:0], 3'b000} + {acc_next[14:0], 1'b0} +
                         {12'd0, mem_q[3:0]};
            end else begin
              phase_next = arlc_pkg::PH_DONE;
            end
          end
          default: phase_next = arlc_pkg::PH_DONE;
        endcase
      end
    end else if (cmd.close) begin
      close_now   = in_tok;
      in_tok_next = 1'b0;
    end
  end

  assign tok_val = neg ? (16'd0 - acc) : acc;

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stopped     <= 1'b0;
      eff         <= '0;
      flags       <= '1;
      in_tok      <= 1'b0;
      tok_cnt     <= '0;
      tok_len     <= '0;
      phase       <= arlc_pkg::PH_WS;
      acc         <= '0;
      neg         <= 1'b0;
      mc_ok       <= 1'b0;
      cand_rssi_v <= 1'b0;
      cand_snr_v  <= 1'b0;
      cand_mc_v   <= 1'b0;
      cand_port_v <= 1'b0;
    end else begin
      if (proc_v && !stopped && mem_q == 8'h00) stopped <= 1'b1;
      if (act) begin
        eff   <= proc_pos + 1'b1;
        flags <= flags_next;
      end
      in_tok  <= in_tok_next;
      tok_cnt <= tok_cnt_next;
      tok_len <= tok_len_next;
      phase   <= phase_next;
      acc     <= acc_next;
      neg     <= neg_next;
      mc_ok   <= mc_ok_next;
      // field commit on token close
      if (close_now) begin
        case (tok_cnt)
          arlc_pkg::TOK_RSSI: begin
            cand_rssi   <= tok_val;
            cand_rssi_v <= 1'b1;
          end
          arlc_pkg::TOK_SNR: begin
            cand_snr   <= tok_val;
            cand_snr_v <= 1'b1;
          end
          arlc_pkg::TOK_MC: begin
            cand_mc   <= mc_ok && (int'(tok_len) == arlc_pkg::MC_LEN);
            cand_mc_v <= 1'b1;
          end
          arlc_pkg::TOK_PORT: begin
            cand_port   <= tok_val[7:0];
            cand_port_v <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // line classification at end of walk
  function automatic logic hit_exact(logic [arlc_pkg::NUM_PAT-1:0] f,
                                     logic [CW-1:0] n, int id);
    return f[id] && (int'(n) == arlc_pkg::pat_off(id) + arlc_pkg::pat_len(id));
  endfunction

  function automatic logic hit_prefix(logic [arlc_pkg::NUM_PAT-1:0] f,
                                      logic [CW-1:0] n, int id);
    return f[id] && (int'(n) >= arlc_pkg::pat_off(id) + arlc_pkg::pat_len(id));
  endfunction

  always_comb begin
    logic is_rx;
    is_rx          = 1'b0;
    kind_c         = arlc_pkg::KIND_STATUS;
    status_c       = arlc_pkg::STS_OK;
    evk_c          = arlc_pkg::EVK_JOINED;
    held_vlen_next = held_vlen;
    if (hit_exact(flags, eff, arlc_pkg::P_OK)) begin
      status_c = arlc_pkg::STS_OK;
    end else if (hit_exact(flags, eff, arlc_pkg::P_PARAM_ERR)) begin
      status_c = arlc_pkg::STS_PARAM_ERR;
    end else if (hit_exact(flags, eff, arlc_pkg::P_BUSY_ERR)) begin
      status_c = arlc_pkg::STS_BUSY;
    end else if (hit_exact(flags, eff, arlc_pkg::P_NO_NET)) begin
      status_c = arlc_pkg::STS_NO_NET;
    end else if (hit_exact(flags, eff, arlc_pkg::P_AT_ERR) ||
                 hit_exact(flags, eff, arlc_pkg::P_RX_ERR)) begin
      status_c = arlc_pkg::STS_ERROR;
    end else if (hit_prefix(flags, eff, arlc_pkg::P_EVT)) begin
      kind_c = arlc_pkg::KIND_EVENT;
      if (hit_prefix(flags, eff, arlc_pkg::P_JOINED)) begin
        evk_c = arlc_pkg::EVK_JOINED;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_JOIN_FAIL)) begin
        evk_c = arlc_pkg::EVK_JOIN_FAIL;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_TX_DONE)) begin
        evk_c = arlc_pkg::EVK_TX_DONE;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_CONF_OK)) begin
        evk_c = arlc_pkg::EVK_CONF_OK;
      end else if (hit_exact(flags, eff, arlc_pkg::P_CONF_FAIL)) begin
        evk_c = arlc_pkg::EVK_CONF_FAIL;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_RX)) begin
        evk_c = arlc_pkg::EVK_RX;
        is_rx = 1'b1;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_P2P_TX)) begin
        evk_c = arlc_pkg::EVK_P2P_TX;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_P2P_RX)) begin
        evk_c = arlc_pkg::EVK_P2P_RX;
      end else if (hit_prefix(flags, eff, arlc_pkg::P_LINKCHECK)) begin
        evk_c = arlc_pkg::EVK_LINKCHECK;
      end else begin
        kind_c = arlc_pkg::KIND_UNKNOWN;
      end
    end else begin
      kind_c         = arlc_pkg::KIND_VALUE;
      held_vlen_next = (int'(eff) > 63) ? 6'd63 : 6'(eff);
    end
    held_rssi_next = (is_rx && cand_rssi_v) ? cand_rssi : held_rssi;
    held_snr_next  = (is_rx && cand_snr_v)  ? cand_snr  : held_snr;
    held_mc_next   = (is_rx && cand_mc_v)   ? cand_mc   : held_mc;
    held_port_next = (is_rx && cand_port_v) ? cand_port : held_port;
  end

  // held values
  always_ff @(posedge clk) begin
    if (rst) begin
      held_rssi <= '0;
      held_snr  <= '0;
      held_mc   <= 1'b0;
      held_port <= '0;
      held_vlen <= '0;
    end else if (cmd.finish) begin
      held_rssi <= held_rssi_next;
      held_snr  <= held_snr_next;
      held_mc   <= held_mc_next;
      held_port <= held_port_next;
      held_vlen <= held_vlen_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      line_kind    <= kind_c;
      status_code  <= status_c;
      event_kind   <= evk_c;
      rx_rssi      <= held_rssi_next;
      rx_snr       <= held_snr_next;
      rx_multicast <= held_mc_next;
      rx_port      <= held_port_next;
      value_length <= held_vlen_next;
    end
  end

endmodule

// ===== hdl/at_response_line_classifier.sv =====
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Top level: byte-wide modem receive in, one classified word per non-empty line out.
// ----------------------------------------------------------------------------
// Bytes other than CR and LF are taken one per cycle while idle into a 64-byte
// line store (63 kept, later bytes dropped). On LF with a non-empty line the
// block stops taking bytes and walks the store once, one stored byte per cycle
// through a single-port read, and holds the input off until its result word is
// loaded; a stalled result holds the block in that last step. Empty lines give
// no word and do not stall the input.
module at_response_line_classifier (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         line_kind,
  output logic [2:0]         status_code,
  output logic [3:0]         event_kind,
  output logic signed [15:0] rx_rssi,
  output logic signed [15:0] rx_snr,
  output logic               rx_multicast,
  output logic [7:0]         rx_port,
  output logic [5:0]         value_length
);

  arlc_pkg::cmd_t  cmd;
  arlc_pkg::stat_t st;

  // sequencer
  arlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // store, matchers and result register
  arlc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .rx_byte      (rx_byte),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .line_kind    (line_kind),
    .status_code  (status_code),
    .event_kind   (event_kind),
    .rx_rssi      (rx_rssi),
    .rx_snr       (rx_snr),
    .rx_multicast (rx_multicast),
    .rx_port      (rx_port),
    .value_length (value_length)
  );

endmodule

// ===== hdl/arlc_checker.sv =====
// ----------------------------------------------------------------------------
// arlc_checker
// Port-level checks on the result word, bound to the classifier top level.
// ----------------------------------------------------------------------------
module arlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] line_kind,
  input logic [2:0] status_code,
  input logic [3:0] event_kind
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_kind) &&
                                $stable(event_kind))
    else $error("stalled result word changed");

  // status code only on status lines
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_kind != arlc_pkg::KIND_STATUS |-> status_code == arlc_pkg::STS_OK)
    else $error("status code on non-status line");

  // event code only on known events, and within range
  a_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_kind != arlc_pkg::KIND_EVENT |-> event_kind == arlc_pkg::EVK_JOINED)
    else $error("event code on non-event line");

  a_evk_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_kind == arlc_pkg::KIND_EVENT |-> event_kind <= arlc_pkg::EVK_MAX)
    else $error("event code out of range");

  // no word right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind at_response_line_classifier arlc_checker u_arlc_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for at_response_line_classifier. Feeds modem byte streams (status
// words, events, rx events with numeric fields, value lines, noise) through
// the input channel with random idling, predicts each line's classification
// and held fields, and checks every output word against the prediction.
// ----------------------------------------------------------------------------
module tb;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         line_kind;
  logic [2:0]         status_code;
  logic [3:0]         event_kind;
  logic signed [15:0] rx_rssi;
  logic signed [15:0] rx_snr;
  logic               rx_multicast;
  logic [7:0]         rx_port;
  logic [5:0]         value_length;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [3:0]  evk;
    logic [15:0] rssi;
    logic [15:0] snr;
    logic        mc;
    logic [7:0]  port;
    logic [5:0]  vlen;
  } line_word_t;

  line_word_t expected_words[$];

  // predictor state
  logic [7:0]  pr_store[arlc_pkg::LINE_BYTES];
  int          pr_count;
  int          pr_eff;
  logic [15:0] pr_rssi;
  logic [15:0] pr_snr;
  logic        pr_mc;
  logic [7:0]  pr_port;
  logic [5:0]  pr_vlen;

  int  errors = 0;
  int  words_checked = 0;
  int  bytes_sent;
  int  cycles = 0;
  bit  quiet;
  bit  hold_req = 1'b0;
  bit  hold_used;
  int  hold_left;
  int  stall_left = 0;

  at_response_line_classifier DUT (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic string str_cat(string a, string b);
    return {a, b};
  endfunction

  function automatic bit text_at(int pos, string s, bit exact);
    if (pos > pr_eff || pr_eff - pos < s.len()) return 0;
    if (exact && pr_eff - pos != s.len()) return 0;
    for (int i = 0; i < s.len(); i++)
      if (pr_store[pos + i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic bit span_equals(int ts, int te, string s);
    if (te - ts != s.len()) return 0;
    for (int i = 0; i < s.len(); i++)
      if (pr_store[ts + i] != s[i]) return 0;
    return 1;
  endfunction

  // colon-separated fields, runs of colons collapse
  function automatic bit field_next(inout int pos, output int ts, output int te);
    int p;
    p = pos;
    ts = 0;
    te = 0;
    while (p < pr_eff && pr_store[p] == arlc_pkg::CH_COLON) p++;
    pos = p;
    if (p >= pr_eff) return 0;
    ts = p;
    while (p < pr_eff && pr_store[p] != arlc_pkg::CH_COLON) p++;
    te = p;
    pos = p;
    return 1;
  endfunction

  function automatic logic [15:0] decimal_value(int ts, int te);
    int p;
    logic [15:0] v;
    bit neg;
    p = ts;
    v = '0;
    neg = 0;
    while (p < te && (pr_store[p] == arlc_pkg::CH_SPACE ||
                      (pr_store[p] >= arlc_pkg::CH_TAB &&
                       pr_store[p] <= arlc_pkg::CH_CR))) p++;
    if (p < te && (pr_store[p] == arlc_pkg::CH_PLUS ||
                   pr_store[p] == arlc_pkg::CH_MINUS)) begin
      neg = (pr_store[p] == arlc_pkg::CH_MINUS);
      p++;
    end
    while (p < te && pr_store[p] >= arlc_pkg::CH_ZERO &&
           pr_store[p] <= arlc_pkg::CH_NINE) begin
      v = v * 16'd10 + 16'(pr_store[p] - arlc_pkg::CH_ZERO);
      p++;
    end
    if (neg) v = -v;
    return v;
  endfunction

  function automatic void rx_fields();
    int pos, ts, te;
    pos = arlc_pkg::EVT_OFF;
    if (!field_next(pos, ts, te)) return;
    if (!field_next(pos, ts, te)) return;
    pr_rssi = decimal_value(ts, te);
    if (!field_next(pos, ts, te)) return;
    pr_snr = decimal_value(ts, te);
    if (!field_next(pos, ts, te)) return;
    pr_mc = span_equals(ts, te, "MULTICAST");
    if (!field_next(pos, ts, te)) return;
    pr_port = 8'(decimal_value(ts, te));
  endfunction

  function automatic int event_code();
    if (text_at(arlc_pkg::EVT_OFF, "JOINED", 0)) return arlc_pkg::EVK_JOINED;
    if (text_at(arlc_pkg::EVT_OFF, str_cat("JOIN", "_FAILED"), 0))
      return arlc_pkg::EVK_JOIN_FAIL;
    if (text_at(arlc_pkg::EVT_OFF, "TX_DONE", 0)) return arlc_pkg::EVK_TX_DONE;
    if (text_at(arlc_pkg::EVT_OFF, str_cat("SEND_CONFIRMED", "_OK"), 0))
      return arlc_pkg::EVK_CONF_OK;
    if (text_at(arlc_pkg::EVT_OFF, str_cat("SEND_CONFIRMED", "_FAILED"), 1))
      return arlc_pkg::EVK_CONF_FAIL;
    if (text_at(arlc_pkg::EVT_OFF, "RX_", 0)) begin
      rx_fields();
      return arlc_pkg::EVK_RX;
    end
    if (text_at(arlc_pkg::EVT_OFF, "TXP2P DONE", 0)) return arlc_pkg::EVK_P2P_TX;
    if (text_at(arlc_pkg::EVT_OFF, "RXP2P", 0)) return arlc_pkg::EVK_P2P_RX;
    if (text_at(arlc_pkg::EVT_OFF, "LINKCHECK", 0)) return arlc_pkg::EVK_LINKCHECK;
    return -1;
  endfunction

  // one accepted byte; returns 1 with a word when a line closes
  function automatic bit classify_byte(logic [7:0] c, output line_word_t w);
    int ev;
    w = '0;
    if (c == arlc_pkg::CH_CR) return 0;
    if (c != arlc_pkg::CH_LF) begin
      if (pr_count < arlc_pkg::LINE_BYTES - 1) begin
        pr_store[pr_count] = c;
        pr_count++;
      end
      return 0;
    end
    if (pr_count == 0) return 0;
    pr_eff = pr_count;
    for (int i = 0; i < pr_count; i++)
      if (pr_store[i] == 8'h00) begin
        pr_eff = i;
        break;
      end
    w.kind = arlc_pkg::KIND_STATUS;
    if (text_at(0, "OK", 1)) w.status = arlc_pkg::STS_OK;
    else if (text_at(0, str_cat("AT_PARAM", "_ERROR"), 1))
      w.status = arlc_pkg::STS_PARAM_ERR;
    else if (text_at(0, str_cat("AT_BUSY", "_ERROR"), 1))
      w.status = arlc_pkg::STS_BUSY;
    else if (text_at(0, str_cat("AT_NO_NETWORK", "_JOINED"), 1))
      w.status = arlc_pkg::STS_NO_NET;
    else if (text_at(0, str_cat("AT_", "ERROR"), 1) ||
             text_at(0, str_cat("AT_RX", "_ERROR"), 1))
      w.status = arlc_pkg::STS_ERROR;
    else if (text_at(0, "+EVT:", 0)) begin
      ev = event_code();
      if (ev < 0) w.kind = arlc_pkg::KIND_UNKNOWN;
      else begin
        w.kind = arlc_pkg::KIND_EVENT;
        w.evk = 4'(ev);
      end
    end else begin
      w.kind = arlc_pkg::KIND_VALUE;
      pr_vlen = (pr_eff > 63) ? 6'd63 : 6'(pr_eff);
    end
    pr_count = 0;
    w.rssi = pr_rssi;
    w.snr = pr_snr;
    w.mc = pr_mc;
    w.port = pr_port;
    w.vlen = pr_vlen;
    return 1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) report_mismatch("unexpected word", 1, 0);
      else begin
        line_word_t e;
        e = expected_words.pop_front();
        words_checked++;
        if (line_kind != e.kind) report_mismatch("line_kind", line_kind, e.kind);
        if (status_code != e.status) report_mismatch("status_code", status_code, e.status);
        if (event_kind != e.evk) report_mismatch("event_kind", event_kind, e.evk);
        if (rx_rssi != e.rssi) report_mismatch("rx_rssi", rx_rssi, $signed(e.rssi));
        if (rx_snr != e.snr) report_mismatch("rx_snr", rx_snr, $signed(e.snr));
        if (rx_multicast != e.mc) report_mismatch("rx_multicast", rx_multicast, e.mc);
        if (rx_port != e.port) report_mismatch("rx_port", rx_port, e.port);
        if (value_length != e.vlen) report_mismatch("value_length", value_length, e.vlen);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // long receiver hold, counted down once when asked
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: long hold when active, otherwise random stall bursts
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // ---------------------------------------------------------------- sending
  task automatic send_byte(logic [7:0] b);
    line_word_t w;
    if (!quiet && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (classify_byte(b, w)) expected_words.push_back(w);
  endtask

  task automatic send_line(string s, bit with_cr = 0);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    if (with_cr) send_byte(arlc_pkg::CH_CR);
    send_byte(arlc_pkg::CH_LF);
  endtask

  function automatic string rand_number();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) s = {s, " "};
      else s = {s, "\t"};
    end
    case ($urandom_range(0, 3))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) return {s, "x"};
    return {s, $sformatf("%0d", $urandom_range(0, 1) ? $urandom_range(0, 999)
                                                     : $urandom_range(0, 9999999))};
  endfunction

  function automatic string rand_text(int n, bit any_byte);
    string s;
    byte b;
    s = "";
    for (int i = 0; i < n; i++) begin
      b = any_byte ? byte'($urandom_range(1, 255)) : byte'($urandom_range(32, 126));
      if (b == arlc_pkg::CH_LF || b == arlc_pkg::CH_CR) b = "#";
      s = {s, string'(b)};
    end
    return s;
  endfunction

  function automatic string rand_colons();
    string s;
    if ($urandom_range(0, 5) == 0) s = "::";
    else s = ":";
    return s;
  endfunction

  function automatic string rand_line();
    string names[9] = '{"JOINED", str_cat("JOIN", "_FAILED"), "TX_DONE",
                        str_cat("SEND_CONFIRMED", "_OK"),
                        str_cat("SEND_CONFIRMED", "_FAILED"), "RX_", "TXP2P DONE",
                        "RXP2P", "LINKCHECK"};
    string stat[7] = '{"OK", str_cat("AT_PARAM", "_ERROR"), str_cat("AT_BUSY", "_ERROR"),
                       str_cat("AT_NO_NETWORK", "_JOINED"), str_cat("AT_", "ERROR"),
                       str_cat("AT_RX", "_ERROR"), "AT_OK"};
    string s;
    string flag;
    int nf;
    case ($urandom_range(0, 9))
      0, 1: begin
        s = stat[$urandom_range(0, 6)];
        if ($urandom_range(0, 4) == 0) s = {s, rand_text(1, 0)};
      end
      2, 3: begin
        s = {"+EVT:", names[$urandom_range(0, 8)]};
        if ($urandom_range(0, 2) == 0) s = {s, ":", rand_text($urandom_range(0, 6), 0)};
      end
      4, 5, 6: begin
        // rx event, fields may be missing, extra ones may follow
        if ($urandom_range(0, 1)) s = "+EVT:RX_B";
        else s = "+EVT:RX_1";
        case ($urandom_range(0, 3))
          0, 1: flag = "MULTICAST";
          2: flag = "UNICAST";
          default: flag = "MULTICASTX";
        endcase
        nf = $urandom_range(0, 5);
        if (nf > 0) s = {s, rand_colons(), rand_number()};
        if (nf > 1) s = {s, rand_colons(), rand_number()};
        if (nf > 2) s = {s, rand_colons(), flag};
        if (nf > 3) s = {s, rand_colons(), rand_number()};
        if (nf > 4) s = {s, ":", rand_text($urandom_range(1, 8), 0)};
        if ($urandom_range(0, 7) == 0) s = {s, ":"};
      end
      7: s = {"+EVT:", rand_text($urandom_range(0, 10), 0)};
      8: s = rand_text($urandom_range(1, 20), 0);
      default: s = rand_text($urandom_range(1, ($urandom_range(0, 5) == 0) ? 80 : 12), 1);
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_status_words();
    send_line("OK", 1);
    send_line(str_cat("AT_PARAM", "_ERROR"));
    send_line(str_cat("AT_BUSY", "_ERROR"));
    send_line(str_cat("AT_NO_NETWORK", "_JOINED"), 1);
    send_line(str_cat("AT_", "ERROR"));
    send_line(str_cat("AT_RX", "_ERROR"));
    send_line("OKX");
  endtask

  task automatic test_events();
    send_line("+EVT:JOINED");
    send_line(str_cat("+EVT:JOIN", "_FAILED_X"));
    send_line("+EVT:TX_DONE");
    send_line(str_cat("+EVT:SEND_CONFIRMED", "_OK"));
    send_line(str_cat("+EVT:SEND_CONFIRMED", "_FAILED"));
    send_line(str_cat("+EVT:SEND_CONFIRMED", "_FAILEDX"));
    send_line("+EVT:RX_1:-32768:+99999:MULTICAST:300");
    send_line("+EVT:RX_B::: \t12 :UNICAST");
    send_line("+EVT:TXP2P DONE");
    send_line("+EVT:RXP2P:1:2");
    send_line("+EVT:LINKCHECK");
    send_line("+EVT:UNKNOWN");
    send_line("+EVT");
  endtask

  task automatic test_odd_lines();
    // empty line, zero byte first and inside, overlong line, bare CR
    send_byte(arlc_pkg::CH_LF);
    send_byte(arlc_pkg::CH_CR);
    send_byte(8'h00);
    send_line("ABC");
    send_line({"OK", string'(8'hFF)});
    send_byte("O");
    send_byte("K");
    send_byte(8'h00);
    send_line("Z");
    send_line(rand_text(75, 1));
  endtask

  task automatic test_random(int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      else send_line(rand_line(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) send_line("+EVT:RX_1:-7:5:MULTICAST:2");
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    clk = 1'b0;
    bytes_sent = 0;
    quiet = 0;
    pr_count = 0;
    pr_eff = 0;
    pr_rssi = '0;
    pr_snr = '0;
    pr_mc = 1'b0;
    pr_port = '0;
    pr_vlen = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_status_words();
    test_events();
    test_odd_lines();
    test_random(500);
    test_backpressure();
    quiet = 1;
    test_random(150);
    @(negedge clk);
    in_valid <= 1'b0;

    // drain
    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d bytes, checked %0d line words", bytes_sent, words_checked);
    $display("covered status words, all event kinds, rx fields, value lines, stalls");
    if (errors == 0 && expected_words.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== at_response_line_classifier.f =====
hdl/arlc_pkg.sv
hdl/arlc_ctrl.sv
hdl/arlc_datapath.sv
hdl/at_response_line_classifier.sv
hdl/arlc_checker.sv
sim/tb.sv
